// ===== hdl/gtme_pkg.sv =====
// Shared constants for the grid tape machine executor: request codes,
// grid geometry and the wrap unit's step count. No dependencies.
package gtme_pkg;

	// request codes; 10..15 are unknown and leave the state alone
	localparam logic [3:0] OP_INC        = 4'd0;
	localparam logic [3:0] OP_DEC        = 4'd1;
	localparam logic [3:0] OP_RIGHT      = 4'd2;
	localparam logic [3:0] OP_LEFT       = 4'd3;
	localparam logic [3:0] OP_UP         = 4'd4;
	localparam logic [3:0] OP_DOWN       = 4'd5;
	localparam logic [3:0] OP_OUT        = 4'd6;
	localparam logic [3:0] OP_READ       = 4'd7;
	localparam logic [3:0] OP_OPEN       = 4'd8;
	localparam logic [3:0] OP_CLOSE      = 4'd9;

	// grid: 256 x 256 byte cells, entry y*256+x
	localparam int CELL_AW  = 16;
	localparam int ADDR_W   = 3;
	localparam int MAX_SIDE = 256;
	localparam int MIN_SIDE_I = 16;
	localparam int TOP_A    = (MAX_SIDE < 256) ? MAX_SIDE : 256;
	localparam int TOP_B    = (TOP_A < MIN_SIDE_I) ? MIN_SIDE_I : TOP_A;
	localparam logic [8:0] MIN_SIDE = 9'(MIN_SIDE_I);
	localparam logic [8:0] SIDE_TOP = 9'(TOP_B);
	localparam logic [8:0] SIDE_RST = 9'd256;

	// restoring reduction: side<<8 down to side<<0
	localparam int WRAP_STEPS = 9;

	// register index
	localparam logic REG_GRID_SIDE = 1'b0;

endpackage

// ===== hdl/grid_tape_machine_executor_core.sv =====
// Grid tape machine executor top level: byte grid memory, pointer,
// modular wrap unit and APB register. Depends on gtme_pkg.
//
// One decoded instruction per request: start is taken when busy is low, and
// the result comes back on out_byte/out_repeat/take_jump with done high for
// one cycle; the receiver cannot stall it. After reset the grid memory is
// swept to zero, one cell per cycle, with busy high. Cell ops (inc, dec, read,
// print, loops, unknown) read the cell from the registered grid memory, then
// execute with the write-back and register the result. Moves run 9 steps of
// the shared restoring modulo unit that wraps the pointer by the side in
// effect, then a memory read at the new pointer, the execute state and the
// registered result. The user must write grid_side only while idle; the
// block itself does not enforce it.
module grid_tape_machine_executor_core import gtme_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [3:0]        req_type,
	input  logic [7:0]        count,
	input  logic [7:0]        in_byte,
	input  logic              in_eof,
	output logic              done,
	output logic [7:0]        out_byte,
	output logic [7:0]        out_repeat,
	output logic              take_jump
);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_WRAP   = 5'b00100,
		S_SETTLE = 5'b01000,
		S_EXEC   = 5'b10000
	} state_t;

	state_t               state_q;
	logic [CELL_AW-1:0]   clr_q;
	logic [8:0]           grid_side_q;
	logic [7:0]           ptr_x_q, ptr_y_q;
	logic [3:0]           op_q;
	logic [7:0]           count_q, byte_q;
	logic                 eof_q, move_y_q;
	logic [12:0]          v_q;
	logic [16:0]          d_q;
	logic [3:0]           step_q;
	logic [7:0]           rdata_q;
	logic                 done_q, jump_q;
	logic [7:0]           byte_out_q, repeat_q;

	logic [7:0]           mem [0:(1<<CELL_AW)-1];

	logic                 accept, cfg_wr;
	logic [8:0]           side_eff;
	logic [CELL_AW-1:0]   rd_addr, waddr;
	logic                 we;
	logic [7:0]           wdata;
	logic [12:0]          v_init, v_nx;
	logic                 v_ge, init_y;
	logic [7:0]           cell_nx;
	logic                 cell_we, jump_nx;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_GRID_SIDE) ? {23'd0, grid_side_q} : 32'd0;

	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;

	always_comb begin
		side_eff = grid_side_q;
		if (grid_side_q < MIN_SIDE) side_eff = MIN_SIDE;
		else if (grid_side_q > SIDE_TOP) side_eff = SIDE_TOP;
	end

	// subtractions add side<<4 (>= 256) first so the value stays positive
	always_comb begin
		v_init = '0;
		init_y = 1'b0;
		case (req_type) inside
			OP_RIGHT: v_init = {5'd0, ptr_x_q} + {5'd0, count};
			OP_LEFT:  v_init = {5'd0, ptr_x_q} + {side_eff, 4'd0} - {5'd0, count};
			OP_UP: begin
				v_init = {5'd0, ptr_y_q} + {side_eff, 4'd0} - {5'd0, count};
				init_y = 1'b1;
			end
			OP_DOWN: begin
				v_init = {5'd0, ptr_y_q} + {5'd0, count};
				init_y = 1'b1;
			end
			default: v_init = '0;
		endcase
	end

	assign v_ge = ({4'd0, v_q} >= d_q);
	assign v_nx = v_ge ? (v_q - d_q[12:0]) : v_q;

	always_comb begin
		cell_nx = rdata_q;
		cell_we = 1'b0;
		jump_nx = 1'b0;
		case (op_q)
			OP_INC: begin
				cell_nx = rdata_q + count_q;
				cell_we = 1'b1;
			end
			OP_DEC: begin
				cell_nx = rdata_q - count_q;
				cell_we = 1'b1;
			end
			OP_READ: begin
				if (count_q != 8'd0) begin
					cell_nx = eof_q ? 8'd0 : byte_q;
					cell_we = 1'b1;
				end
			end
			OP_OPEN:  jump_nx = (rdata_q == 8'd0);
			OP_CLOSE: jump_nx = (rdata_q != 8'd0);
			default:  cell_nx = rdata_q;
		endcase
	end

	assign rd_addr = {ptr_y_q, ptr_x_q};

	always_comb begin
		we    = 1'b0;
		waddr = rd_addr;
		wdata = cell_nx;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = 8'd0;
		end else if (state_q == S_EXEC) begin
			we = cell_we;
		end
	end

	// grid memory, read every cycle at the pointer
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req_type;
			count_q  <= count;
			byte_q   <= in_byte;
			eof_q    <= in_eof;
			move_y_q <= init_y;
			v_q      <= v_init;
			d_q      <= {side_eff, 8'd0};
			step_q   <= '0;
		end else if (state_q == S_WRAP) begin
			v_q    <= v_nx;
			d_q    <= d_q >> 1;
			step_q <= step_q + 4'd1;
		end
		if (state_q == S_EXEC) begin
			byte_out_q <= cell_nx;
			repeat_q   <= (op_q == OP_OUT) ? count_q : 8'd0;
			jump_q     <= jump_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			grid_side_q <= SIDE_RST;
			ptr_x_q     <= '0;
			ptr_y_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			if (cfg_wr && paddr[2] == REG_GRID_SIDE) grid_side_q <= pwdata[8:0];
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CELL_AW'(1);
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						case (req_type) inside
							OP_RIGHT, OP_LEFT, OP_UP, OP_DOWN: state_q <= S_WRAP;
							default: state_q <= S_EXEC;
						endcase
					end
				end
				S_WRAP: begin
					if (step_q == 4'(WRAP_STEPS - 1)) begin
						if (move_y_q) ptr_y_q <= v_nx[7:0];
						else ptr_x_q <= v_nx[7:0];
						state_q <= S_SETTLE;
					end
				end
				S_SETTLE: state_q <= S_EXEC;
				S_EXEC:   state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign out_byte   = byte_out_q;
	assign out_repeat = repeat_q;
	assign take_jump  = jump_q;

	// a result is always followed by a cycle without one
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done high two cycles in a row");

	// a wrapped pointer lands inside the side in effect
	a_wrap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SETTLE) |->
		((move_y_q ? {1'b0, ptr_y_q} : {1'b0, ptr_x_q}) < side_eff))
		else $error("pointer wrap out of range");

	// pointer moves only at the end of a wrap
	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_WRAP) |=> ($stable(ptr_x_q) && $stable(ptr_y_q)))
		else $error("pointer changed outside a move");

	// an accepted cell op passes through S_EXEC before done carries its result
	a_cell_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !(req_type == OP_RIGHT || req_type == OP_LEFT ||
		req_type == OP_UP || req_type == OP_DOWN)) |=> ##1 done)
		else $error("cell op result missing");

endmodule

// ===== verif/gtme_checker.sv =====
`timescale 1ns / 1ps
// Checker for the grid tape machine executor: keeps its own grid, pointer and
// side, predicts each request's outcome and compares it with the done strobe.
// Depends on gtme_pkg.
module gtme_checker import gtme_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              start,
	input  logic              busy,
	input  logic [3:0]        req_type,
	input  logic [7:0]        count,
	input  logic [7:0]        in_byte,
	input  logic              in_eof,
	input  logic              done,
	input  logic [7:0]        out_byte,
	input  logic [7:0]        out_repeat,
	input  logic              take_jump,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [7:0] val;
		logic [7:0] rep;
		logic       jump;
	} outcome_t;

	logic [7:0] grid [0:65535];
	logic [7:0] px;
	logic [7:0] py;
	logic [8:0] side_reg;
	outcome_t   outcome_q [$];

	function automatic int side_now();
		if (side_reg < MIN_SIDE)
			return int'(MIN_SIDE);
		if (side_reg > SIDE_TOP)
			return int'(SIDE_TOP);
		return int'(side_reg);
	endfunction

	// a pointer left beyond a shrunken side is reduced by the true modulo first
	function automatic logic [7:0] wrap_fwd(logic [7:0] p, logic [7:0] c, int s);
		return 8'(((int'(p) % s) + (int'(c) % s)) % s);
	endfunction

	function automatic logic [7:0] wrap_back(logic [7:0] p, logic [7:0] c, int s);
		return 8'(((int'(p) % s) + s - (int'(c) % s)) % s);
	endfunction

	function automatic outcome_t exec_instr(logic [3:0] op, logic [7:0] cnt,
			logic [7:0] byt, logic eof);
		outcome_t   r;
		int         s;
		logic [15:0] here;
		s = side_now();
		here = {py, px};
		r = '0;
		case (op)
			OP_INC:        grid[here] = grid[here] + cnt;
			OP_DEC:        grid[here] = grid[here] - cnt;
			OP_RIGHT:      px = wrap_fwd(px, cnt, s);
			OP_LEFT:       px = wrap_back(px, cnt, s);
			OP_UP:         py = wrap_back(py, cnt, s);
			OP_DOWN:       py = wrap_fwd(py, cnt, s);
			OP_OUT:        r.rep = cnt;
			OP_READ: begin
				if (cnt != 8'd0)
					grid[here] = eof ? 8'd0 : byt;
			end
			OP_OPEN:       r.jump = (grid[here] == 8'd0);
			OP_CLOSE:      r.jump = (grid[here] != 8'd0);
			default: ;
		endcase
		r.val = grid[{py, px}];
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < 65536; i++)
				grid[i] = 8'd0;
			px = 8'd0;
			py = 8'd0;
			side_reg = SIDE_RST;
			outcome_q.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %0h/%0h/%0b",
						$time, out_byte, out_repeat, take_jump);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("out_byte", want.val, out_byte);
					check_field("out_repeat", want.rep, out_repeat);
					check_field("take_jump", want.jump, take_jump);
				end
			end
			if (start && !busy)
				outcome_q.push_back(exec_instr(req_type, count, in_byte, in_eof));
			// writes to any index other than grid_side are dropped
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_GRID_SIDE)
				side_reg = pwdata[8:0];
		end
		pending = outcome_q.size();
	end

endmodule

// ===== verif/tb_grid_tape_machine_executor_core.sv =====
`timescale 1ns / 1ps
// Testbench top for grid_tape_machine_executor_core: drives requests and
// APB register writes, gives the verdict. Depends on gtme_pkg and gtme_checker.
module tb_grid_tape_machine_executor_core import gtme_pkg::*; ();

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              start;
	logic              busy;
	logic [3:0]        req_type;
	logic [7:0]        count;
	logic [7:0]        in_byte;
	logic              in_eof;
	logic              done;
	logic [7:0]        out_byte;
	logic [7:0]        out_repeat;
	logic              take_jump;
	int                fail_count;
	int                pending;
	int                idle_pct;

	// sides per random phase, including ones that saturate
	int side_plan [9] = '{256, 16, 100, 0, 511, 37, 255, 17, 300};

	grid_tape_machine_executor_core uut (.*);

	gtme_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("grid_tape_machine_executor_core test failed");
		$finish;
	end

	task automatic issue(input logic [3:0] op, input logic [7:0] cnt,
			input logic [7:0] byt, input logic eof);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start    <= 1'b0;
			req_type <= 4'($urandom);
			count    <= 8'($urandom);
			in_byte  <= 8'($urandom);
			in_eof   <= 1'($urandom);
			@(negedge clk);
		end
		start    <= 1'b1;
		req_type <= op;
		count    <= cnt;
		in_byte  <= byt;
		in_eof   <= eof;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		start <= 1'b0;
		while (busy || pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic rand_request();
		logic [3:0] op;
		logic [7:0] cnt;
		int         r;
		op = ($urandom_range(99) < 4) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
		r = $urandom_range(99);
		// moves stay short most of the time so cells get revisited
		if (r < 10)
			cnt = (r < 5) ? 8'd0 : 8'd255;
		else if (op inside {OP_RIGHT, OP_LEFT, OP_UP, OP_DOWN} && r < 85)
			cnt = 8'($urandom_range(0, 3));
		else if (r < 35)
			cnt = 8'($urandom_range(0, 3));
		else
			cnt = 8'($urandom);
		issue(op, cnt, 8'($urandom), $urandom_range(99) < 25);
	endtask

	initial begin
		logic [8:0] side;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		start    = 1'b0;
		req_type = OP_INC;
		count    = 8'd0;
		in_byte  = 8'd0;
		in_eof   = 1'b0;
		idle_pct = 29;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// grid clear runs after reset with busy high
		wait_quiet();
		reg_write(ADDR_W'(REG_GRID_SIDE) << 2, 32'd256);

		issue(OP_OUT, 8'd0, 8'h00, 1'b0);
		issue(OP_OUT, 8'd255, 8'hff, 1'b1);
		issue(OP_OPEN, 8'd0, 8'h00, 1'b0);
		issue(OP_CLOSE, 8'd255, 8'h00, 1'b0);
		issue(OP_INC, 8'd255, 8'h00, 1'b0);
		issue(OP_INC, 8'd1, 8'h00, 1'b0);
		issue(OP_DEC, 8'd1, 8'h00, 1'b0);
		issue(OP_DEC, 8'd255, 8'h00, 1'b0);
		issue(OP_INC, 8'd5, 8'h00, 1'b0);
		issue(OP_OPEN, 8'd255, 8'h00, 1'b0);
		issue(OP_CLOSE, 8'd0, 8'h00, 1'b0);
		// read with zero count keeps the cell; eof stores zero
		issue(OP_READ, 8'd0, 8'ha5, 1'b0);
		issue(OP_READ, 8'd1, 8'ha5, 1'b0);
		issue(OP_READ, 8'd255, 8'hff, 1'b1);
		issue(OP_READ, 8'd9, 8'hff, 1'b0);
		issue(OP_LEFT, 8'd1, 8'h00, 1'b0);
		issue(OP_UP, 8'd1, 8'h00, 1'b0);
		issue(OP_RIGHT, 8'd255, 8'h00, 1'b0);
		issue(OP_DOWN, 8'd255, 8'h00, 1'b0);
		issue(OP_RIGHT, 8'd0, 8'h00, 1'b0);
		issue(4'd10, 8'd255, 8'h00, 1'b0);
		issue(4'd15, 8'haa, 8'h55, 1'b1);
		issue(OP_DOWN, 8'd200, 8'h00, 1'b0);
		issue(OP_RIGHT, 8'd200, 8'h00, 1'b0);
		issue(OP_INC, 8'd77, 8'h00, 1'b0);

		// shrink the side with the pointer parked beyond it
		wait_quiet();
		reg_write(ADDR_W'(REG_GRID_SIDE) << 2, 32'd16);
		issue(OP_OUT, 8'd3, 8'h00, 1'b0);
		issue(OP_RIGHT, 8'd1, 8'h00, 1'b0);
		issue(OP_UP, 8'd1, 8'h00, 1'b0);
		issue(OP_OUT, 8'd1, 8'h00, 1'b0);

		for (int ph = 0; ph < 9; ph++) begin
			idle_pct = (ph < 3) ? 29 : (ph < 6) ? 53 : 0;
			side = 9'(side_plan[ph]);
			wait_quiet();
			reg_write(ADDR_W'(4), $urandom);
			reg_write(ADDR_W'(REG_GRID_SIDE) << 2,
				(ph % 2) ? {23'($urandom), side} : {23'd0, side});
			for (int n = 0; n < 156; n++)
				rand_request();
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("grid_tape_machine_executor_core test passed");
		else
			$display("grid_tape_machine_executor_core test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/gtme_pkg.sv
hdl/grid_tape_machine_executor_core.sv
verif/gtme_checker.sv
verif/tb_grid_tape_machine_executor_core.sv
